>>> hw/rtl/hp_pkg.sv
// Shared types and constants of the Hoare partition block.
package hp_pkg;

    // Fixed field widths at the ports
    localparam int ELEM_W      = 32;
    localparam int POS_W       = 6;
    localparam int TDATA_OUT_W = 48;
    localparam int OUT_PAD_W   = TDATA_OUT_W - ELEM_W - 2 * POS_W;

    // Result of the shared element/pivot compare
    typedef struct packed {
        logic lt;
        logic gt;
    } cmp_res_t;

endpackage

>>> hw/rtl/hp_ram.sv
// Generic single-write, single-read RAM with registered read data.
module hp_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // Write port and registered read port
    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

>>> hw/rtl/hp_cmp.sv
// Shared signed compare of a stored element against the pivot.
module hp_cmp #(
    parameter int WIDTH = 32
) (
    input  logic signed [WIDTH-1:0] elem,
    input  logic signed [WIDTH-1:0] pivot,
    output hp_pkg::cmp_res_t        res
);

    // One magnitude compare serves both pointer walks
    always_comb begin
        res.lt = (elem < pivot);
        res.gt = (elem > pivot);
    end

endmodule

>>> hw/rtl/hoare_partition.sv
// Top level of the Hoare partition block: sequencer, element store and output register.
//
// Usage: array elements arrive on the s_ channel, one request each; s_tlast marks the
// final element. Up to DEPTH elements are kept; further ones are dropped and the
// array is flagged in m_tuser. On the last element the block partitions the store in
// place around element 0 (Hoare scheme) and then sends the whole array on the m_
// channel, one request per element, carrying its position and the split index j;
// m_tlast marks the final element.
// Sequence: the partition fetches the pivot (store read, then read latency), then
// advances a pointer per compare, stops each walk in its check state, and each swap adds a
// second write, then a re-read of the left element, all set by the single read port
// of the store and the one shared compare unit. Output reads the store, then loads the
// output register, for each element. s_tready is low from the last element until
// the final result sits in the output register.
// Stall: while m_tready is low the output register holds its request and the walk
// over the store waits; the next array may start loading while the final result of
// the previous one still waits.
// Reset: aresetn (synchronous, active low) empties the block; store contents are
// left undefined and need no clearing.
module hoare_partition #(
    parameter int DEPTH      = 64,
    parameter int DATA_WIDTH = 32
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [31:0] s_tdata,   // [31:0] value
    input  logic        s_tlast,
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [hp_pkg::TDATA_OUT_W-1:0] m_tdata, // [31:0] element, [37:32] position,
                                                    // [43:38] split_index, [47:44] zero
    output logic        m_tlast,
    output logic        m_tuser    // [0] overflow
);

    localparam int IDX_W = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH + 1);

    typedef enum logic [3:0] {
        ST_LOAD,
        ST_P_RD,
        ST_P_LAT,
        ST_L_RD,
        ST_L_CHK,
        ST_R_CHK,
        ST_SWAP,
        ST_O_RD,
        ST_O_LAT
    } state_t;

    state_t state_reg, state_next;
    logic [CNT_W-1:0] fill_reg, fill_next;
    logic             ovf_reg, ovf_next;
    logic [IDX_W-1:0] i_reg, i_next;
    logic [IDX_W-1:0] j_reg, j_next;
    logic [IDX_W-1:0] last_idx_reg, last_idx_next;
    logic [IDX_W-1:0] split_reg, split_next;
    logic [IDX_W-1:0] k_reg, k_next;
    logic signed [DATA_WIDTH-1:0] pivot_reg, pivot_next;
    logic [DATA_WIDTH-1:0] a_reg, a_next;

    logic                      m_valid_reg, m_valid_next;
    logic [hp_pkg::ELEM_W-1:0] m_elem_reg, m_elem_next;
    logic [hp_pkg::POS_W-1:0]  m_pos_reg, m_pos_next;
    logic [hp_pkg::POS_W-1:0]  m_split_reg, m_split_next;
    logic                      m_last_reg, m_last_next;
    logic                      m_ovf_reg, m_ovf_next;

    logic                  ram_we;
    logic [IDX_W-1:0]      ram_waddr, ram_raddr;
    logic [DATA_WIDTH-1:0] ram_wdata, ram_rdata;
    logic signed [DATA_WIDTH-1:0] in_value;
    hp_pkg::cmp_res_t      cmp;

    // Input value held at store width (wrapped or sign-extended)
    assign in_value = DATA_WIDTH'($signed(s_tdata));

    hp_ram #(
        .WIDTH (DATA_WIDTH),
        .DEPTH (DEPTH)
    ) u_store (
        .aclk  (aclk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    hp_cmp #(
        .WIDTH (DATA_WIDTH)
    ) u_cmp (
        .elem  ($signed(ram_rdata)),
        .pivot (pivot_reg),
        .res   (cmp)
    );

    // Sequencer: load, pivot fetch, pointer walks, swaps, output sweep
    always_comb begin
        state_next    = state_reg;
        fill_next     = fill_reg;
        ovf_next      = ovf_reg;
        i_next        = i_reg;
        j_next        = j_reg;
        last_idx_next = last_idx_reg;
        split_next    = split_reg;
        k_next        = k_reg;
        pivot_next    = pivot_reg;
        a_next        = a_reg;
        m_valid_next  = m_valid_reg && !m_tready;
        m_elem_next   = m_elem_reg;
        m_pos_next    = m_pos_reg;
        m_split_next  = m_split_reg;
        m_last_next   = m_last_reg;
        m_ovf_next    = m_ovf_reg;
        ram_we        = 1'b0;
        ram_waddr     = i_reg;
        ram_wdata     = ram_rdata;
        ram_raddr     = i_reg;
        case (state_reg)
            ST_LOAD: begin
                if (s_tvalid) begin
                    if (fill_reg < CNT_W'(DEPTH)) begin
                        ram_we    = 1'b1;
                        ram_waddr = fill_reg[IDX_W-1:0];
                        ram_wdata = in_value;
                        fill_next = fill_reg + CNT_W'(1);
                    end else begin
                        ovf_next = 1'b1;
                    end
                    if (s_tlast) begin
                        state_next = ST_P_RD;
                    end
                end
            end
            ST_P_RD: begin
                ram_raddr  = '0;
                state_next = ST_P_LAT;
            end
            ST_P_LAT: begin
                // pivot arrives; start the left walk at element 0
                pivot_next    = $signed(ram_rdata);
                last_idx_next = IDX_W'(fill_reg - CNT_W'(1));
                i_next        = '0;
                j_next        = IDX_W'(fill_reg - CNT_W'(1));
                ram_raddr     = '0;
                state_next    = ST_L_CHK;
            end
            ST_L_RD: begin
                ram_raddr  = i_reg;
                state_next = ST_L_CHK;
            end
            ST_L_CHK: begin
                if (i_reg != last_idx_reg && cmp.lt) begin
                    i_next    = i_reg + IDX_W'(1);
                    ram_raddr = i_reg + IDX_W'(1);
                end else begin
                    a_next     = ram_rdata;
                    ram_raddr  = j_reg;
                    state_next = ST_R_CHK;
                end
            end
            ST_R_CHK: begin
                if (j_reg != '0 && cmp.gt) begin
                    j_next    = j_reg - IDX_W'(1);
                    ram_raddr = j_reg - IDX_W'(1);
                end else if (i_reg >= j_reg) begin
                    split_next = j_reg;
                    k_next     = '0;
                    state_next = ST_O_RD;
                end else begin
                    // first half of the swap: right element goes left
                    ram_we     = 1'b1;
                    ram_waddr  = i_reg;
                    ram_wdata  = ram_rdata;
                    state_next = ST_SWAP;
                end
            end
            ST_SWAP: begin
                ram_we     = 1'b1;
                ram_waddr  = j_reg;
                ram_wdata  = a_reg;
                i_next     = i_reg + IDX_W'(1);
                j_next     = j_reg - IDX_W'(1);
                state_next = ST_L_RD;
            end
            ST_O_RD: begin
                ram_raddr = k_reg;
                if (!m_valid_reg || m_tready) begin
                    state_next = ST_O_LAT;
                end
            end
            ST_O_LAT: begin
                m_valid_next = 1'b1;
                m_elem_next  = hp_pkg::ELEM_W'($signed(ram_rdata));
                m_pos_next   = hp_pkg::POS_W'(k_reg);
                m_split_next = hp_pkg::POS_W'(split_reg);
                m_last_next  = (k_reg == last_idx_reg);
                m_ovf_next   = ovf_reg;
                if (k_reg == last_idx_reg) begin
                    fill_next  = '0;
                    ovf_next   = 1'b0;
                    state_next = ST_LOAD;
                end else begin
                    k_next     = k_reg + IDX_W'(1);
                    state_next = ST_O_RD;
                end
            end
            default: begin
                state_next = ST_LOAD;
            end
        endcase
    end

    // State and registered outputs
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_LOAD;
            fill_reg    <= '0;
            ovf_reg     <= 1'b0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            fill_reg    <= fill_next;
            ovf_reg     <= ovf_next;
            m_valid_reg <= m_valid_next;
        end
        i_reg        <= i_next;
        j_reg        <= j_next;
        last_idx_reg <= last_idx_next;
        split_reg    <= split_next;
        k_reg        <= k_next;
        pivot_reg    <= pivot_next;
        a_reg        <= a_next;
        m_elem_reg   <= m_elem_next;
        m_pos_reg    <= m_pos_next;
        m_split_reg  <= m_split_next;
        m_last_reg   <= m_last_next;
        m_ovf_reg    <= m_ovf_next;
    end

    assign s_tready = (state_reg == ST_LOAD);
    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {{hp_pkg::OUT_PAD_W{1'b0}}, m_split_reg, m_pos_reg, m_elem_reg};
    assign m_tlast  = m_last_reg;
    assign m_tuser  = m_ovf_reg;

    // Fill count never runs past the store
    a_fill_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        fill_reg <= CNT_W'(DEPTH))
        else $error("fill count beyond store depth");

    // Pointers stay inside the stored array during the walks
    a_ptr_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_L_CHK || state_reg == ST_R_CHK)
        |-> (i_reg <= last_idx_reg && j_reg <= last_idx_reg))
        else $error("partition pointer outside array");

    // Last element starts the pivot fetch
    a_last_starts: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_tvalid && s_tready && s_tlast) |=> (state_reg == ST_P_RD))
        else $error("last element did not start partition");

    // Output register is free whenever a result is loaded into it
    a_out_free: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_O_LAT) |-> !m_valid_reg)
        else $error("result overwrote a waiting request");

endmodule

>>> test/hoare_partition_tb.sv
// Testbench of hoare_partition: streams signed arrays and checks each partitioned result.
`timescale 1ns / 1ps

module hoare_partition_tb;

    localparam int STORE_DEPTH = 64;
    localparam int STALL_LIMIT = 5000;  // cycles with no request moving on either side
    localparam int LONG_HOLD   = 300;   // receiver hold-off for the pressure test
    localparam int TAIL_CYCLES = 200;

    // One element of an emitted, partitioned array
    typedef struct packed {
        logic signed [hp_pkg::ELEM_W-1:0] element;
        logic [hp_pkg::POS_W-1:0]         position;
        logic [hp_pkg::POS_W-1:0]         split_index;
        logic                             last_out;
        logic                             overflow;
    } part_elem_t;

    logic              aclk;
    logic              aresetn;
    logic              s_tvalid;
    logic              s_tready;
    logic [31:0]       s_tdata;    // [31:0] value
    logic              s_tlast;
    logic              m_tvalid;
    logic              m_tready;
    logic [hp_pkg::TDATA_OUT_W-1:0] m_tdata; // [31:0] element, [37:32] position,
                                             // [43:38] split_index, [47:44] zero
    logic              m_tlast;
    logic              m_tuser;    // [0] overflow

    // Predictor state: the array being loaded
    logic signed [hp_pkg::ELEM_W-1:0] array_store [STORE_DEPTH];
    int                               load_count;
    bit                               drop_flag;
    part_elem_t                       partition_q[$];
    logic signed [hp_pkg::ELEM_W-1:0] array_buf[$];

    int fail_count;
    int src_idle_pct;
    int dst_idle_pct;
    int hold_trigger;
    int hold_seen;
    int hold_left;
    int stall_cycles;

    hoare_partition #(
        .DEPTH      (STORE_DEPTH),
        .DATA_WIDTH (hp_pkg::ELEM_W)
    ) u_dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tlast  (s_tlast),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast),
        .m_tuser  (m_tuser)
    );

    // 100 MHz clock
    always begin
        aclk = 1'b0;
        #5;
        aclk = 1'b1;
        #5;
    end

    // Hoare partition of the loaded array around element 0; queues every element
    task automatic partition_and_queue();
        int                               lo;
        int                               hi;
        int                               n;
        int                               split;
        bit                               done;
        logic signed [hp_pkg::ELEM_W-1:0] pivot;
        logic signed [hp_pkg::ELEM_W-1:0] tmp;
        part_elem_t                       res;
        n     = load_count;
        pivot = array_store[0];
        lo    = 0;
        hi    = n - 1;
        done  = 1'b0;
        split = 0;
        while (!done) begin
            while (lo < n - 1 && array_store[lo] < pivot)
                lo++;
            while (hi > 0 && array_store[hi] > pivot)
                hi--;
            if (lo >= hi) begin
                split = hi;
                done  = 1'b1;
            end else begin
                tmp              = array_store[lo];
                array_store[lo]  = array_store[hi];
                array_store[hi]  = tmp;
                lo++;
                hi--;
            end
        end
        for (int k = 0; k < n; k++) begin
            res.element     = array_store[k];
            res.position    = k[hp_pkg::POS_W-1:0];
            res.split_index = split[hp_pkg::POS_W-1:0];
            res.last_out    = (k == n - 1);
            res.overflow    = drop_flag;
            partition_q.push_back(res);
        end
    endtask

    // Input monitor: load each accepted request, partition on the last one
    always @(posedge aclk) begin
        if (aresetn && s_tvalid && s_tready) begin
            if (load_count < STORE_DEPTH) begin
                array_store[load_count] = s_tdata;
                load_count++;
            end else begin
                drop_flag = 1'b1;
            end
            if (s_tlast) begin
                partition_and_queue();
                load_count = 0;
                drop_flag  = 1'b0;
            end
        end
    end

    task automatic compare_field(input string name, input longint exp_v, input longint act_v);
        if (exp_v !== act_v) begin
            $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, exp_v, act_v);
            fail_count++;
        end
    endtask

    // Output checker: every accepted result against the oldest expectation
    always @(posedge aclk) begin
        part_elem_t want;
        if (aresetn && m_tvalid && m_tready) begin
            if (partition_q.size() == 0) begin
                $display("%0t: unexpected result, expected none, actual element %0h",
                         $time, m_tdata[hp_pkg::ELEM_W-1:0]);
                fail_count++;
            end else begin
                want = partition_q.pop_front();
                compare_field("element", want.element,
                              $signed(m_tdata[hp_pkg::ELEM_W-1:0]));
                compare_field("position", want.position,
                              m_tdata[hp_pkg::ELEM_W +: hp_pkg::POS_W]);
                compare_field("split_index", want.split_index,
                              m_tdata[hp_pkg::ELEM_W + hp_pkg::POS_W +: hp_pkg::POS_W]);
                compare_field("padding", 0,
                              m_tdata[hp_pkg::TDATA_OUT_W-1 -: hp_pkg::OUT_PAD_W]);
                compare_field("last_out", want.last_out, m_tlast);
                compare_field("overflow", want.overflow, m_tuser);
            end
        end
    end

    // Receiver: random stalls, plus a long hold-off on request
    always @(negedge aclk) begin
        if (hold_trigger != hold_seen) begin
            hold_seen = hold_trigger;
            hold_left = LONG_HOLD;
        end
        if (hold_left > 0) begin
            hold_left--;
            m_tready <= 1'b0;
        end else begin
            m_tready <= ($urandom_range(99) >= dst_idle_pct);
        end
    end

    // Watchdog on cycles where nothing moves
    always @(posedge aclk) begin
        if (!aresetn || (s_tvalid && s_tready) || (m_tvalid && m_tready))
            stall_cycles = 0;
        else
            stall_cycles++;
        if (stall_cycles >= STALL_LIMIT) begin
            $display("%0t: no request accepted for %0d cycles", $time, STALL_LIMIT);
            $display("hoare_partition verification failed");
            $finish;
        end
    end

    // Offer one element; called and returns at a falling edge
    task automatic send_value(input logic signed [hp_pkg::ELEM_W-1:0] value, input bit is_last);
        while ($urandom_range(99) < src_idle_pct) begin
            s_tvalid <= 1'b0;
            @(negedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= value;
        s_tlast  <= is_last;
        @(posedge aclk);
        while (!s_tready)
            @(posedge aclk);
        @(negedge aclk);
    endtask

    // Send the contents of array_buf as one array
    task automatic send_array();
        for (int k = 0; k < array_buf.size(); k++)
            send_value(array_buf[k], k == array_buf.size() - 1);
        array_buf.delete();
    endtask

    function automatic logic signed [hp_pkg::ELEM_W-1:0] pick_value(input int kind);
        case (kind)
            0:       return $urandom;
            1:       return $signed($urandom_range(6)) - 3;
            default: begin
                case ($urandom_range(4))
                    0:       return 32'sh8000_0000;
                    1:       return 32'sh7fff_ffff;
                    2:       return 0;
                    3:       return -1;
                    default: return $urandom;
                endcase
            end
        endcase
    endfunction

    task automatic test_single_element();
        array_buf = '{32'sd5};
        send_array();
        array_buf = '{32'sh8000_0000};
        send_array();
    endtask

    task automatic test_extremes();
        array_buf = '{32'sd0, 32'sh7fff_ffff, 32'sh8000_0000, -32'sd1, 32'sd1};
        send_array();
        array_buf = '{32'sd9, -32'sd9};
        send_array();
    endtask

    task automatic test_equal_values();
        array_buf = '{32'sd7, 32'sd7, 32'sd7, 32'sd7};
        send_array();
    endtask

    task automatic test_ordered();
        array_buf = '{-32'sd2, -32'sd1, 32'sd0, 32'sd1, 32'sd2};
        send_array();
        array_buf = '{32'sd3, 32'sd2, 32'sd1, 32'sd0, -32'sd1};
        send_array();
    endtask

    // Store full: the last element itself is dropped, array still ends
    task automatic test_overflow();
        for (int k = 0; k < STORE_DEPTH + 2; k++)
            array_buf.push_back(pick_value(k % 3));
        send_array();
    endtask

    // Random arrays, mostly short, a few full or overflowing
    task automatic test_random(input int n_items);
        int sent;
        int len;
        int kind;
        int r;
        sent = 0;
        while (sent < n_items) begin
            r = $urandom_range(99);
            if (r < 70)
                len = $urandom_range(8, 1);
            else if (r < 95)
                len = $urandom_range(STORE_DEPTH, 9);
            else
                len = $urandom_range(STORE_DEPTH + 4, STORE_DEPTH + 1);
            if (len > n_items - sent)
                len = n_items - sent;
            kind = $urandom_range(2);
            for (int k = 0; k < len; k++)
                array_buf.push_back(pick_value(kind));
            send_array();
            sent += len;
        end
    endtask

    // Receiver holds off while arrays keep coming, so the input stalls
    task automatic test_backpressure();
        hold_trigger++;
        for (int a = 0; a < 3; a++) begin
            for (int k = 0; k < 12; k++)
                array_buf.push_back(pick_value(a));
            send_array();
        end
    endtask

    initial begin
        aresetn      = 1'b0;
        s_tvalid     = 1'b0;
        s_tdata      = '0;
        s_tlast      = 1'b0;
        m_tready     = 1'b0;
        load_count   = 0;
        drop_flag    = 1'b0;
        fail_count   = 0;
        hold_trigger = 0;
        hold_seen    = 0;
        hold_left    = 0;
        stall_cycles = 0;
        src_idle_pct = 32;
        dst_idle_pct = 64;
        repeat (2) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        test_single_element();
        test_extremes();
        test_equal_values();
        test_ordered();
        test_overflow();
        test_random(30);

        src_idle_pct = 64;
        dst_idle_pct = 32;
        test_random(30);

        src_idle_pct = 0;
        dst_idle_pct = 0;
        test_backpressure();
        test_random(20);

        s_tvalid <= 1'b0;
        while (partition_q.size() != 0)
            @(posedge aclk);
        repeat (TAIL_CYCLES) @(posedge aclk);

        if (fail_count == 0)
            $display("hoare_partition verification clean");
        else
            $display("hoare_partition verification failed");
        $finish;
    end

endmodule
